>>> design/sep_pkg.sv
// Shared types and character codes of the event-stream field parser.
package sep_pkg;

   localparam logic [7:0] CH_CR = 8'h0D;
   localparam logic [7:0] CH_LF = 8'h0A;
   localparam logic [7:0] CH_SP = 8'h20;

   localparam int unsigned MaxResults = 3;

   typedef enum logic [1:0] {
      KIND_ID    = 2'd0,
      KIND_EVENT = 2'd1,
      KIND_DATA  = 2'd2,
      KIND_END   = 2'd3
   } field_kind_type;

   typedef enum logic [1:0] {
      PH_START  = 2'd0,
      PH_NAME   = 2'd1,
      PH_VALUE  = 2'd2,
      PH_IGNORE = 2'd3
   } phase_type;

   typedef struct packed {
      logic [7:0]     out_byte;
      field_kind_type field_kind;
      logic           value_restart;
      logic           is_last;
   } result_type;

   // results caused by one input byte, lowest index first
   typedef struct packed {
      result_type [MaxResults-1:0] items;
      logic [1:0]                  count;
   } batch_type;

endpackage

>>> design/sep_parser.sv
// Line parser: state register and the per-byte next-state and result logic.
module sep_parser (
   input  logic               clock,
   input  logic               reset,
   input  logic               fire,
   input  logic [7:0]         in_byte,
   output sep_pkg::batch_type batch
);
   import sep_pkg::*;

   typedef struct packed {
      phase_type      phase;
      logic [2:0]     pos;
      field_kind_type field;
      logic           cr_held;
      logic           value_begun;
      logic           data_seen;
   } parser_state_type;

   typedef struct packed {
      parser_state_type st;
      logic [1:0]       cnt;
      result_type       r0;
      result_type       r1;
   } take_result_type;

   parser_state_type state_ff, state_in;

   function automatic logic [2:0] name_len(field_kind_type f);
      logic [2:0] len;
      unique case (f)
         KIND_ID:    len = 3'd3;
         KIND_EVENT: len = 3'd6;
         KIND_DATA:  len = 3'd5;
         default:    len = 3'd7;
      endcase
      return len;
   endfunction

   function automatic logic [7:0] name_char(field_kind_type f, logic [2:0] p);
      logic [7:0] ch;
      ch = 8'h00;
      case (f)
         KIND_ID: begin
            case (p)
               3'd0:    ch = "i";
               3'd1:    ch = "d";
               3'd2:    ch = ":";
               default: ch = 8'h00;
            endcase
         end
         KIND_EVENT: begin
            case (p)
               3'd0:    ch = "e";
               3'd1:    ch = "v";
               3'd2:    ch = "e";
               3'd3:    ch = "n";
               3'd4:    ch = "t";
               3'd5:    ch = ":";
               default: ch = 8'h00;
            endcase
         end
         KIND_DATA: begin
            case (p)
               3'd0:    ch = "d";
               3'd1:    ch = "a";
               3'd2:    ch = "t";
               3'd3:    ch = "a";
               3'd4:    ch = ":";
               default: ch = 8'h00;
            endcase
         end
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   function automatic take_result_type take_content(parser_state_type s, logic [7:0] b);
      take_result_type c;
      c     = '0;
      c.st  = s;
      unique case (s.phase)
         PH_START: begin
            c.st.phase = PH_NAME;
            c.st.pos   = 3'd1;
            if (b == "i") begin
               c.st.field = KIND_ID;
            end else if (b == "e") begin
               c.st.field = KIND_EVENT;
            end else if (b == "d") begin
               c.st.field = KIND_DATA;
            end else begin
               c.st.phase = PH_IGNORE;
               c.st.pos   = s.pos;
            end
         end
         PH_NAME: begin
            if (s.pos < name_len(s.field) && b == name_char(s.field, s.pos)) begin
               c.st.pos = s.pos + 3'd1;
               // pos stays below the length, so equality marks the colon
               if (s.pos + 3'd1 == name_len(s.field)) begin
                  c.st.phase       = PH_VALUE;
                  c.st.value_begun = 1'b0;
               end
            end else begin
               c.st.phase = PH_IGNORE;
            end
         end
         PH_VALUE: begin
            if (s.value_begun) begin
               c.r0.out_byte   = b;
               c.r0.field_kind = s.field;
               c.cnt           = 2'd1;
            end else if (b != CH_SP) begin
               c.st.value_begun = 1'b1;
               if (s.field == KIND_DATA) begin
                  c.st.data_seen = 1'b1;
               end
               if (s.field == KIND_DATA && s.data_seen) begin
                  // join LF ahead of a later data line
                  c.r0.out_byte   = CH_LF;
                  c.r0.field_kind = KIND_DATA;
                  c.r1.out_byte   = b;
                  c.r1.field_kind = s.field;
                  c.cnt           = 2'd2;
               end else begin
                  c.r0.out_byte      = b;
                  c.r0.field_kind    = s.field;
                  c.r0.value_restart = 1'b1;
                  c.cnt              = 2'd1;
               end
            end
         end
         default: begin
         end
      endcase
      return c;
   endfunction

   function automatic batch_type add_content(batch_type bt, take_result_type c);
      batch_type r;
      r = bt;
      if (c.cnt != 2'd0) begin
         r.items[r.count] = c.r0;
         r.count          = r.count + 2'd1;
      end
      if (c.cnt == 2'd2) begin
         r.items[r.count] = c.r1;
         r.count          = r.count + 2'd1;
      end
      return r;
   endfunction

   function automatic batch_type add_end(batch_type bt);
      batch_type r;
      r                          = bt;
      r.items[r.count]           = '0;
      r.items[r.count].field_kind = KIND_END;
      r.count                    = r.count + 2'd1;
      return r;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '{phase: PH_START, pos: 3'd0, field: KIND_ID,
                       cr_held: 1'b0, value_begun: 1'b0, data_seen: 1'b0};
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      parser_state_type s;
      batch_type        bt;
      take_result_type  c;
      logic             consumed;
      s        = state_ff;
      bt       = '0;
      c        = '0;
      consumed = 1'b0;

      if (s.cr_held) begin
         s.cr_held = 1'b0;
         if (in_byte == CH_LF) begin
            if (s.phase == PH_START) begin
               bt          = add_end(bt);
               s.data_seen = 1'b0;
            end
            s.phase       = PH_START;
            s.pos         = 3'd0;
            s.value_begun = 1'b0;
            consumed      = 1'b1;
         end else begin
            // lone CR is content, ahead of the byte after it
            c  = take_content(s, CH_CR);
            s  = c.st;
            bt = add_content(bt, c);
         end
      end

      if (!consumed) begin
         if (in_byte == CH_CR) begin
            s.cr_held = 1'b1;
         end else if (in_byte == CH_LF) begin
            if (s.phase == PH_START) begin
               bt          = add_end(bt);
               s.data_seen = 1'b0;
            end
            s.phase       = PH_START;
            s.pos         = 3'd0;
            s.value_begun = 1'b0;
         end else begin
            c  = take_content(s, in_byte);
            s  = c.st;
            bt = add_content(bt, c);
         end
      end

      if (bt.count != 2'd0) begin
         bt.items[bt.count - 2'd1].is_last = 1'b1;
      end

      batch    = bt;
      state_in = fire ? s : state_ff;
   end

endmodule

>>> design/sep_out_queue.sv
// Result register: holds the results of one byte and hands them out a beat at a time.
module sep_out_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  sep_pkg::batch_type  batch,
   input  logic                pop_ready,
   output logic                space,
   output logic                head_valid,
   output sep_pkg::result_type head
);
   import sep_pkg::*;

   result_type [MaxResults-1:0] items_ff, items_in;
   logic [1:0]                  cnt_ff, cnt_in;
   logic                        pop;

   assign head_valid = (cnt_ff != 2'd0);
   assign head       = items_ff[0];
   assign pop        = head_valid && pop_ready;
   // a new batch fits once the last waiting beat leaves
   assign space      = (cnt_ff == 2'd0) || (cnt_ff == 2'd1 && pop);

   always_comb begin
      items_in = items_ff;
      cnt_in   = cnt_ff;
      if (load) begin
         items_in = batch.items;
         cnt_in   = batch.count;
      end else if (pop) begin
         items_in[0] = items_ff[1];
         items_in[1] = items_ff[2];
         cnt_in      = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      items_ff <= items_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

endmodule

>>> design/sse_event_field_parser.sv
// Top level of the event-stream field parser.
// Takes one stream byte per beat and emits the id, event and data value bytes of each
// field line, tagged with their field, plus an event-end beat for each blank line.
// A byte is taken into an input register and parsed once the result register has room,
// its zero to three results landing in a small result register that drains one beat per
// cycle while rsp_tready is high. The block takes a byte every cycle while each byte
// yields at most one result and the result side is ready; a byte with more results
// holds the single result port for one beat each, which sets the sustained byte rate.
// No clearing pass is needed after reset.
module sse_event_field_parser (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic [2:0] rsp_tuser,   // [1:0] field_kind, [2] value_restart
   output logic       rsp_tlast    // is_last
);
   import sep_pkg::*;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       fire;
   logic       space;
   batch_type  batch;
   result_type head;

   assign fire       = in_valid_ff && space;
   assign req_tready = !in_valid_ff || fire;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
      end
   end

   sep_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .fire    (fire),
      .in_byte (in_byte_ff),
      .batch   (batch)
   );

   sep_out_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .load       (fire),
      .batch      (batch),
      .pop_ready  (rsp_tready),
      .space      (space),
      .head_valid (rsp_tvalid),
      .head       (head)
   );

   assign rsp_tdata = head.out_byte;
   assign rsp_tuser = {head.value_restart, head.field_kind};
   assign rsp_tlast = head.is_last;

endmodule

>>> design/sep_checker.sv
// Port-level checks of the field parser, bound to its top level.
module sep_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic [2:0] rsp_tuser,
   input logic       rsp_tlast
);
   import sep_pkg::*;

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result beat changed while stalled");

   // an event end is the sole result of its byte
   a_end_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1:0] == KIND_END |->
         rsp_tdata == 8'h00 && !rsp_tuser[2] && rsp_tlast)
      else $error("malformed event-end beat");

   // a data LF can only be a join, which always has a byte after it
   a_join_lf: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1:0] == KIND_DATA && rsp_tdata == CH_LF |->
         !rsp_tuser[2] && !rsp_tlast)
      else $error("join LF marked as restart or last");

   // nothing waiting on the result side means a byte can be taken
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with no result pending");

   // while a byte is offered, the ready signal is never unknown
   a_req_known: assert property (@(posedge clock) disable iff (reset)
      req_tvalid |-> !$isunknown(req_tready))
      else $error("input ready unknown while a byte is offered");

endmodule

bind sse_event_field_parser sep_checker u_sep_checker (.*);

>>> sim/sse_event_field_parser_test.sv
// Self-checking testbench for the event-stream field parser, with its own line-parsing model.
`timescale 1ns / 100ps

module sse_event_field_parser_test;

   import sep_pkg::*;

   localparam int unsigned StallLimit = 1000;
   localparam int unsigned TailCycles = 16;
   localparam int unsigned RandomBytes = 360;

   // Follows the line syntax byte by byte and queues the beats the block should emit.
   class field_line_scoreboard;
      phase_type      phase;
      logic [2:0]     match_len;
      field_kind_type field;
      logic           cr_waiting;
      logic           value_open;
      logic           event_has_data;
      result_type     expected_beats[$];
      int unsigned    mismatches;
      int unsigned    checked;
      int unsigned    event_ends;

      function new();
         phase          = PH_START;
         match_len      = '0;
         field          = KIND_ID;
         cr_waiting     = 1'b0;
         value_open     = 1'b0;
         event_has_data = 1'b0;
         mismatches     = 0;
         checked        = 0;
         event_ends     = 0;
      endfunction

      function string field_name(field_kind_type f);
         case (f)
            KIND_ID:    return "id:";
            KIND_EVENT: return "event:";
            default:    return "data:";
         endcase
      endfunction

      function void push(logic [7:0] b, field_kind_type k, logic restart);
         expected_beats.push_back('{out_byte: b, field_kind: k, value_restart: restart,
                                    is_last: 1'b0});
      endfunction

      function void take_content(logic [7:0] b);
         string name;
         logic  restart;
         case (phase)
            PH_START: begin
               phase = PH_NAME;
               match_len = 3'd1;
               if (b == "i") field = KIND_ID;
               else if (b == "e") field = KIND_EVENT;
               else if (b == "d") field = KIND_DATA;
               else phase = PH_IGNORE;
            end
            PH_NAME: begin
               name = field_name(field);
               if (match_len < name.len() && b == name[match_len]) begin
                  match_len = match_len + 3'd1;
                  if (match_len == name.len()) begin
                     phase = PH_VALUE;
                     value_open = 1'b0;
                  end
               end else begin
                  phase = PH_IGNORE;
               end
            end
            PH_VALUE: begin
               if (value_open) begin
                  push(b, field, 1'b0);
               end else if (b != CH_SP) begin
                  value_open = 1'b1;
                  restart = 1'b1;
                  if (field == KIND_DATA) begin
                     // second and later data lines of an event are joined by LF
                     if (event_has_data) begin
                        push(CH_LF, KIND_DATA, 1'b0);
                        restart = 1'b0;
                     end
                     event_has_data = 1'b1;
                  end
                  push(b, field, restart);
               end
            end
            default: ;
         endcase
      endfunction

      function void end_line();
         if (phase == PH_START) begin
            push(8'h00, KIND_END, 1'b0);
            event_has_data = 1'b0;
            event_ends++;
         end
         phase = PH_START;
         match_len = '0;
         value_open = 1'b0;
      endfunction

      function void parse_byte(logic [7:0] b);
         int unsigned queued_at_start;
         logic        lf_taken;
         queued_at_start = expected_beats.size();
         lf_taken = 1'b0;
         // a held CR is resolved by the byte after it
         if (cr_waiting) begin
            cr_waiting = 1'b0;
            if (b == CH_LF) begin
               end_line();
               lf_taken = 1'b1;
            end else begin
               take_content(CH_CR);
            end
         end
         if (!lf_taken) begin
            if (b == CH_CR) cr_waiting = 1'b1;
            else if (b == CH_LF) end_line();
            else take_content(b);
         end
         if (expected_beats.size() > queued_at_start)
            expected_beats[expected_beats.size() - 1].is_last = 1'b1;
      endfunction

      function void check_beat(result_type got);
         result_type want;
         if (expected_beats.size() == 0) begin
            $error("result beat with nothing expected: out_byte %h kind %0d",
                   got.out_byte, got.field_kind);
            mismatches++;
            return;
         end
         want = expected_beats.pop_front();
         checked++;
         if (got.out_byte !== want.out_byte) begin
            $error("out_byte: expected %h, got %h", want.out_byte, got.out_byte);
            mismatches++;
         end
         if (got.field_kind !== want.field_kind) begin
            $error("field_kind: expected %0d, got %0d", want.field_kind, got.field_kind);
            mismatches++;
         end
         if (got.value_restart !== want.value_restart) begin
            $error("value_restart: expected %b, got %b", want.value_restart,
                   got.value_restart);
            mismatches++;
         end
         if (got.is_last !== want.is_last) begin
            $error("is_last: expected %b, got %b", want.is_last, got.is_last);
            mismatches++;
         end
      endfunction

      function int unsigned outstanding();
         return expected_beats.size();
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'h00;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;
   logic [2:0] rsp_tuser;
   logic       rsp_tlast;

   field_line_scoreboard board;
   logic        no_stall = 1'b0;
   int unsigned sent_bytes = 0;
   int unsigned ignored_bytes = 0;
   int unsigned idle_cycles = 0;

   sse_event_field_parser i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #4 clock = ~clock;

   // result side: check each beat, stall now and then
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready)
            board.check_beat('{out_byte: rsp_tdata,
                               field_kind: field_kind_type'(rsp_tuser[1:0]),
                               value_restart: rsp_tuser[2], is_last: rsp_tlast});
         rsp_tready <= no_stall || ($urandom_range(0, 99) >= 16);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= StallLimit) begin
         $display("FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_byte(input logic [7:0] b);
      while (!no_stall && $urandom_range(0, 99) < 16) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.parse_byte(b);
      sent_bytes++;
   endtask

   task automatic send_text(input string s);
      int unsigned i;
      for (i = 0; i < s.len(); i++) send_byte(s[i]);
   endtask

   task automatic send_eol();
      if ($urandom_range(0, 9) < 3) send_byte(CH_CR);
      send_byte(CH_LF);
   endtask

   // anything but LF; CR and space boosted so lone CRs and inner spaces turn up often
   function automatic logic [7:0] random_content();
      int unsigned r;
      logic [7:0]  b;
      r = $urandom_range(0, 99);
      if (r < 8) return CH_CR;
      if (r < 14) return CH_SP;
      b = 8'($urandom_range(0, 255));
      return (b == CH_LF) ? 8'h5A : b;
   endfunction

   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (board.outstanding() != 0) @(posedge clock);
   endtask

   task automatic send_random_line();
      int unsigned pick, n, i, k, start_count;
      string       name;
      logic [7:0]  b;
      start_count = sent_bytes;
      pick = $urandom_range(0, 99);
      k = $urandom_range(0, 9);
      name = (k < 2) ? "id:" : (k < 4) ? "event:" : "data:";
      if (pick < 12) begin
         send_eol();
      end else if (pick < 80) begin
         send_text(name);
         if ($urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 3);
            for (i = 0; i < n; i++) send_byte(CH_SP);
         end
         n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
         for (i = 0; i < n; i++) send_byte(random_content());
         send_eol();
      end else if (pick < 90) begin
         // name broken off at some position up to and including the colon
         n = $urandom_range(0, name.len() - 1);
         for (i = 0; i < n; i++) send_byte(name[i]);
         b = random_content();
         send_byte((b == name[n]) ? (b ^ 8'h01) : b);
         n = $urandom_range(0, 3);
         for (i = 0; i < n; i++) send_byte(random_content());
         send_eol();
         ignored_bytes += sent_bytes - start_count;
      end else begin
         n = $urandom_range(0, 6);
         for (i = 0; i < n; i++) send_byte(random_content());
         send_eol();
         ignored_bytes += sent_bytes - start_count;
      end
   endtask

   initial begin
      int unsigned line_count;
      board = new();
      line_count = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // blank line with no fields still ends an event
      send_byte(CH_LF);
      // leading spaces skipped, NUL is a value byte
      send_text("data: ");
      send_byte(8'h00);
      send_byte(CH_LF);
      // second data line: join LF, then a lone CR in the value
      send_text("data:");
      send_byte(8'hFF);
      send_byte(CH_CR);
      send_byte(8'h01);
      send_byte(CH_LF);
      // empty id value, CRLF ending
      send_text("id:");
      send_byte(CH_CR);
      send_byte(CH_LF);
      send_byte(CH_CR);
      send_byte(CH_LF);
      drain_results();

      while (sent_bytes - ignored_bytes < RandomBytes) begin
         no_stall <= (line_count >= 40 && line_count < 80);
         if (line_count == 25 || line_count == 120) drain_results();
         send_random_line();
         line_count++;
      end
      send_byte(CH_LF);

      req_tvalid <= 1'b0;
      while (board.outstanding() != 0) @(posedge clock);
      repeat (TailCycles) @(posedge clock);

      $display("Streamed %0d bytes over %0d random lines: id, event and data fields,",
               sent_bytes, line_count);
      $display("broken names, lone CRs and CRLF endings; %0d beats checked, %0d event ends.",
               board.checked, board.event_ends);
      if (board.mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
